@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold on every clock outside reset
`define AC3_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ac3 check failed: condition");

// condition in this cycle implies a condition in the next cycle
`define AC3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ac3 check failed: sequence");

`endif

@@ rtl/ac3sfa_pkg.sv @@
// types, constants and rate tables of the ac3 sync frame assembler
package ac3sfa_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 3840;

  localparam logic [15:0] SYNC_WORD  = 16'h0B77;
  localparam logic [15:0] HUNT_FILL  = 16'hFFFF;
  localparam logic [7:0]  SYNC_HI    = 8'h0B;
  localparam logic [7:0]  SYNC_LO    = 8'h77;
  localparam logic [7:0]  BSID_LIMIT = 8'h60;
  localparam logic [5:0]  FRMSIZE_LIMIT = 6'd38;

  // frame positions of interest
  localparam logic [11:0] POS_AFTER_SYNC = 12'd2;
  localparam logic [11:0] POS_SIZE_CODE  = 12'd4;
  localparam logic [11:0] POS_BSID       = 12'd5;

  typedef enum logic [1:0] {
    FS_48K  = 2'd0,
    FS_44K1 = 2'd1,
    FS_32K  = 2'd2,
    FS_RSVD = 2'd3
  } fscod_t;

  // one result item
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        frame_first;
    logic        frame_last;
    logic        header_error;
    logic [11:0] frame_bytes;
    logic        run_end;
  } res_t;

  // results produced by one request, written to the output queue together
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // nominal bit rate in kbit/s
  function automatic logic [9:0] rate_kbps(input logic [4:0] idx);
    logic [9:0] r;
    case (idx)
      5'd0:    r = 10'd32;
      5'd1:    r = 10'd40;
      5'd2:    r = 10'd48;
      5'd3:    r = 10'd56;
      5'd4:    r = 10'd64;
      5'd5:    r = 10'd80;
      5'd6:    r = 10'd96;
      5'd7:    r = 10'd112;
      5'd8:    r = 10'd128;
      5'd9:    r = 10'd160;
      5'd10:   r = 10'd192;
      5'd11:   r = 10'd224;
      5'd12:   r = 10'd256;
      5'd13:   r = 10'd320;
      5'd14:   r = 10'd384;
      5'd15:   r = 10'd448;
      5'd16:   r = 10'd512;
      5'd17:   r = 10'd576;
      5'd18:   r = 10'd640;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // floor(320 * rate / 147), the 44.1 kHz frame length in 16-bit words
  function automatic logic [10:0] rate_44k1(input logic [4:0] idx);
    logic [10:0] r;
    case (idx)
      5'd0:    r = 11'd69;
      5'd1:    r = 11'd87;
      5'd2:    r = 11'd104;
      5'd3:    r = 11'd121;
      5'd4:    r = 11'd139;
      5'd5:    r = 11'd174;
      5'd6:    r = 11'd208;
      5'd7:    r = 11'd243;
      5'd8:    r = 11'd278;
      5'd9:    r = 11'd348;
      5'd10:   r = 11'd417;
      5'd11:   r = 11'd487;
      5'd12:   r = 11'd557;
      5'd13:   r = 11'd696;
      5'd14:   r = 11'd835;
      5'd15:   r = 11'd975;
      5'd16:   r = 11'd1114;
      5'd17:   r = 11'd1253;
      5'd18:   r = 11'd1393;
      default: r = 11'd0;
    endcase
    return r;
  endfunction

  // frame length in bytes, zero when the header is invalid
  function automatic logic [11:0] frame_length(input logic [7:0] code,
                                               input logic [7:0] bsid_byte);
    logic [5:0]  fsc;
    logic [4:0]  idx;
    logic [9:0]  rate;
    logic [12:0] len;
    fsc  = code[5:0];
    idx  = fsc[5:1];
    rate = rate_kbps(idx);
    case (fscod_t'(code[7:6]))
      FS_48K:  len = {1'b0, rate, 2'b00};
      FS_44K1: len = {({1'b0, rate_44k1(idx)} + {11'd0, fsc[0]}), 1'b0};
      FS_32K:  len = {1'b0, rate, 2'b00} + {2'b00, rate, 1'b0};
      default: len = 13'd0;
    endcase
    if (bsid_byte >= BSID_LIMIT || fsc >= FRMSIZE_LIMIT ||
        len > 13'(MAX_FRAME_BYTES)) begin
      len = 13'd0;
    end
    return len[11:0];
  endfunction

endpackage

@@ rtl/ac3sfa_stream_if.sv @@
// valid/ready channel interfaces for the byte stream and the frame results
interface ac3sfa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       flush;

  modport source (output valid, output in_byte, output flush, input ready);
  modport sink   (input valid, input in_byte, input flush, output ready);
endinterface

interface ac3sfa_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        frame_first;
  logic        frame_last;
  logic        header_error;
  logic [11:0] frame_bytes;
  logic        run_end;

  modport source (output valid, output out_byte, output frame_first, output frame_last,
                  output header_error, output frame_bytes, output run_end,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_first, input frame_last,
                  input header_error, input frame_bytes, input run_end,
                  output ready);
endinterface

@@ rtl/ac3sfa_out_fifo.sv @@
// four-entry result queue taking up to two results per cycle
module ac3sfa_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  ac3sfa_pkg::push_t push,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_ready,
  output ac3sfa_pkg::res_t  out_res
);

  ac3sfa_pkg::res_t mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 3'd0);
  assign out_res   = mem_r[rd_ptr_r];
  assign room2     = (count_r <= 3'd2);

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push.cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push.r1;
    end
  end

endmodule

@@ rtl/ac3sfa_parser.sv @@
// request register, sync hunt, frame position tracking and header check
module ac3sfa_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [7:0]        req_byte,
  input  logic              req_flush,
  input  logic              room2,
  output ac3sfa_pkg::push_t push
);

  logic        stg_valid_r;
  logic [7:0]  stg_byte_r;
  logic        stg_flush_r;
  logic        adv;

  logic [15:0] shift_r, shift_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic [11:0] pos_r, pos_nxt;
  logic [11:0] target_r, target_nxt;
  logic [7:0]  code_r, code_nxt;

  assign adv       = stg_valid_r && room2;
  assign req_ready = !stg_valid_r || adv;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (req_ready) begin
      stg_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      stg_byte_r  <= req_byte;
      stg_flush_r <= req_flush;
    end
  end

  // per-byte frame logic
  always_comb begin
    logic [11:0] tgt;
    logic [11:0] len;
    logic        err;
    logic        last;
    shift_nxt    = shift_r;
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    target_nxt   = target_r;
    code_nxt     = code_r;
    push         = '0;
    tgt          = target_r;
    len          = '0;
    err          = 1'b0;
    last         = 1'b0;
    if (adv) begin
      if (stg_flush_r) begin
        shift_nxt    = ac3sfa_pkg::HUNT_FILL;
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        target_nxt   = '0;
        code_nxt     = '0;
      end else if (!in_frame_r) begin
        // hunting: look for the sync word
        shift_nxt = {shift_r[7:0], stg_byte_r};
        if (shift_nxt == ac3sfa_pkg::SYNC_WORD) begin
          in_frame_nxt          = 1'b1;
          pos_nxt               = ac3sfa_pkg::POS_AFTER_SYNC;
          target_nxt            = '0;
          push.cnt              = 2'd2;
          push.r0.out_byte      = ac3sfa_pkg::SYNC_HI;
          push.r0.frame_first   = 1'b1;
          push.r1.out_byte      = ac3sfa_pkg::SYNC_LO;
          push.r1.run_end       = 1'b1;
        end
      end else begin
        if (pos_r == ac3sfa_pkg::POS_SIZE_CODE) begin
          code_nxt = stg_byte_r;
        end
        // header check at the bsid byte
        if (pos_r == ac3sfa_pkg::POS_BSID) begin
          len = ac3sfa_pkg::frame_length(code_r, stg_byte_r);
          if (len == 12'd0) begin
            err = 1'b1;
          end else begin
            tgt = len;
          end
        end
        last = !err && (pos_r >= ac3sfa_pkg::POS_BSID) &&
               (({1'b0, pos_r} + 13'd1) >= {1'b0, tgt});
        push.cnt         = 2'd1;
        push.r0.out_byte = stg_byte_r;
        push.r0.run_end  = 1'b1;
        if (err || last) begin
          push.r0.header_error = err;
          push.r0.frame_last   = last;
          push.r0.frame_bytes  = err ? 12'd0 : tgt;
          shift_nxt            = ac3sfa_pkg::HUNT_FILL;
          in_frame_nxt         = 1'b0;
          pos_nxt              = '0;
          target_nxt           = '0;
        end else begin
          push.r0.frame_bytes = tgt;
          target_nxt          = tgt;
          pos_nxt             = pos_r + 12'd1;
        end
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= ac3sfa_pkg::HUNT_FILL;
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      target_r   <= '0;
      code_r     <= '0;
    end else begin
      shift_r    <= shift_nxt;
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      target_r   <= target_nxt;
      code_r     <= code_nxt;
    end
  end

endmodule

@@ rtl/ac3_sync_frame_assembler_top.sv @@
// top level of the ac3 sync frame assembler
//
// in_chan takes one stream byte per request (in_byte, flush). While hunting,
// bytes only enter the 16-bit sync register; when it reads 0x0B77 the block
// emits 0x0B (frame_first) and 0x77, then every frame byte as it arrives.
// frame_bytes carries the frame length from the bsid byte (position 5) on.
// A bad header gives header_error on the position-5 byte, the last byte of a
// frame gives frame_last; both return to hunting. flush on a request drops
// any frame and returns the parser state to reset, with no result.
// A result passes the request register and the result queue before it is
// offered on out_chan; both sync bytes enter the queue together, and the
// second is offered once the first is accepted. Throughput is one request
// per cycle while two queue entries are free, set by the request register
// and the parser step. Results wait in a four-entry queue; the request
// register stalls when fewer than two free entries remain, so a stalled
// receiver backs up into in_chan.ready after a few requests. Synchronous
// reset clears the queue and returns the parser to hunting.
module ac3_sync_frame_assembler_top (
  input  logic          clk,
  input  logic          rst_n,
  ac3sfa_in_if.sink     in_chan,
  ac3sfa_out_if.source  out_chan
);

  ac3sfa_pkg::push_t push;
  ac3sfa_pkg::res_t  out_res;
  logic              room2;

  // byte parser
  ac3sfa_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_chan.valid),
    .req_ready (in_chan.ready),
    .req_byte  (in_chan.in_byte),
    .req_flush (in_chan.flush),
    .room2     (room2),
    .push      (push)
  );

  // result queue
  ac3sfa_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  // result fields to the channel
  assign out_chan.out_byte     = out_res.out_byte;
  assign out_chan.frame_first  = out_res.frame_first;
  assign out_chan.frame_last   = out_res.frame_last;
  assign out_chan.header_error = out_res.header_error;
  assign out_chan.frame_bytes  = out_res.frame_bytes;
  assign out_chan.run_end      = out_res.run_end;

endmodule

@@ rtl/ac3sfa_checker.sv @@
// port-level checks of the ac3 sync frame assembler, bound to the top level
`include "assert_macros.svh"

module ac3sfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        frame_first,
  input logic        frame_last,
  input logic        header_error,
  input logic [11:0] frame_bytes,
  input logic        run_end
);

  // a stalled result keeps its byte
  `AC3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte))

  // the first sync byte opens a run and carries no size
  `AC3_ASSERT_ALWAYS(a_first_shape, !(out_valid && frame_first) || (out_byte == ac3sfa_pkg::SYNC_HI && !run_end && frame_bytes == 12'd0))

  // the second sync byte follows at once
  `AC3_ASSERT_NEXT(a_sync_pair, out_valid && out_ready && frame_first, out_valid && out_byte == ac3sfa_pkg::SYNC_LO && run_end)

  // a rejected header ends its run with no size
  `AC3_ASSERT_ALWAYS(a_error_shape, !(out_valid && header_error) || (run_end && !frame_last && frame_bytes == 12'd0))

  // a closing byte carries the parsed size
  `AC3_ASSERT_ALWAYS(a_last_shape, !(out_valid && frame_last) || (run_end && frame_bytes != 12'd0))

endmodule

bind ac3_sync_frame_assembler_top ac3sfa_checker u_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_byte     (out_chan.out_byte),
  .frame_first  (out_chan.frame_first),
  .frame_last   (out_chan.frame_last),
  .header_error (out_chan.header_error),
  .frame_bytes  (out_chan.frame_bytes),
  .run_end      (out_chan.run_end)
);
